// ----- hw/rtl/kct_pkg.sv -----
`default_nettype none

package kct_pkg;

  // Field widths of the command and result ports.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // Default table size.
  localparam int CAPACITY_DEF = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the item and compare its key against every entry
    logic exec;   // resolve the command, update the table and the result
  } kct_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kct_ctrl.sv -----
`default_nettype none

module kct_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  output logic                  done,
  output kct_pkg::kct_ctl_t     ctl
);
  import kct_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Next state: an accepted item passes through the execute step and returns to idle.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
    end
  end

  // Handshake and datapath commands.
  assign busy     = (state != S_IDLE);
  assign ctl.load = start && (state == S_IDLE);
  assign ctl.exec = (state == S_EXEC);

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> ctl.exec)
    else $error("accepted item did not move to the execute step");

  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> (done && !busy))
    else $error("execute step did not end in a result strobe");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.exec))
    else $error("result strobe without an execute step");

endmodule

`default_nettype wire

// ----- hw/rtl/kct_datapath.sv -----
`default_nettype none

module kct_datapath #(
  parameter int CAPACITY = kct_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire kct_pkg::kct_ctl_t             ctl,
  input  wire logic [kct_pkg::CMD_W-1:0]     command,
  input  wire logic [kct_pkg::KEY_W-1:0]     entry_key,
  input  wire logic [kct_pkg::HANDLE_W-1:0]  entry_handle,
  output logic      [kct_pkg::STATUS_W-1:0]  status,
  output logic      [kct_pkg::POS_W-1:0]     found_position,
  output logic      [kct_pkg::HANDLE_W-1:0]  handle_out,
  output logic      [kct_pkg::COUNT_W-1:0]   entry_count
);
  import kct_pkg::*;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int POS_X_W = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int CNT_X_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  // Table cells and occupancy.
  logic [KEY_W-1:0]    keys    [CAPACITY];
  logic [HANDLE_W-1:0] handles [CAPACITY];
  logic [CNT_W-1:0]    held_count;
  logic [CNT_W-1:0]    count_next;

  // Captured item and match vector.
  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [CAPACITY-1:0] match_now;
  logic [CAPACITY-1:0] match_q;

  // Resolution of the command.
  logic [CAPACITY-1:0] seen;
  logic                hit;
  logic                full;
  logic [IDX_W-1:0]    first_idx;
  logic [IDX_W-1:0]    ins_idx;
  logic [HANDLE_W-1:0] sel_handle;
  logic                do_insert;
  logic                do_remove;
  logic [STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]    pos_next;
  logic [HANDLE_W-1:0] hout_next;
  logic [POS_X_W-1:0]  pos_ext;
  logic [CNT_X_W-1:0]  cnt_ext;

  // Every occupied cell compares its key with the incoming key.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_now[i] = (CNT_W'(i) < held_count) && (keys[i] == entry_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q    <= command;
      key_q    <= entry_key;
      handle_q <= entry_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= '0;
    end else if (ctl.load) begin
      match_q <= match_now;
    end
  end

  // First matching position, and the cells at or above it for compaction.
  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) first_idx = IDX_W'(i);
    end
    seen[0] = match_q[0];
    for (int i = 1; i < CAPACITY; i++) begin
      seen[i] = seen[i-1] | match_q[i];
    end
  end

  assign hit        = |match_q;
  assign full       = (held_count == FULL_COUNT);
  assign ins_idx    = held_count[IDX_W-1:0];
  assign sel_handle = handles[first_idx];

  // Decide the outcome of the command.
  always_comb begin
    status_next = STAT_OK;
    pos_next    = '0;
    hout_next   = '0;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    count_next  = held_count;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else if (hit) begin
          status_next = STAT_DUP;
        end else begin
          do_insert  = 1'b1;
          pos_next   = ins_idx;
          count_next = held_count + 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          pos_next  = first_idx;
          hout_next = sel_handle;
        end else begin
          status_next = STAT_MISS;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          do_remove  = 1'b1;
          pos_next   = first_idx;
          hout_next  = sel_handle;
          count_next = held_count - 1'b1;
        end else begin
          status_next = STAT_MISS;
        end
      end
      default: begin
        status_next = STAT_OK;
      end
    endcase
  end

  // Each cell loads the new entry; every cell but the top one takes its upper neighbor on removal.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g < CAPACITY - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (ctl.exec) begin
          if (do_insert && (ins_idx == IDX_W'(g))) begin
            keys[g]    <= key_q;
            handles[g] <= handle_q;
          end else if (do_remove && seen[g]) begin
            keys[g]    <= keys[g+1];
            handles[g] <= handles[g+1];
          end
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (ctl.exec && do_insert && (ins_idx == IDX_W'(g))) begin
          keys[g]    <= key_q;
          handles[g] <= handle_q;
        end
      end
    end
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (ctl.exec) begin
      held_count <= count_next;
    end
  end

  // Result registers, shown with the strobe in the following cycle.
  assign pos_ext = POS_X_W'(pos_next);
  assign cnt_ext = CNT_X_W'(count_next);

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status         <= status_next;
      found_position <= pos_ext[POS_W-1:0];
      handle_out     <= hout_next;
      entry_count    <= cnt_ext[COUNT_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= FULL_COUNT)
    else $error("entry count above capacity");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_q))
    else $error("key held in more than one occupied cell");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && (cmd_q == CMD_REMOVE) && hit) |=>
      (held_count == $past(held_count) - 1'b1))
    else $error("removal did not drop the count by one");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && (status_next != STAT_OK)) |=> $stable(held_count))
    else $error("refused command changed the count");

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_compacting_table_unit.sv -----
`default_nettype none

// A command accepted with start has its key compared across all cells and is captured;
// the execute step (select, shift, count update) follows, and its result, marked by
// done, is registered as the execute step ends. busy is high in the execute step, so
// the unit takes no new command until the last one has been resolved.
// Reset (rst, synchronous) empties the table; the receiver cannot stall results.
module keyed_compacting_table_unit #(
  parameter int CAPACITY = kct_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [kct_pkg::CMD_W-1:0]     command,
  input  wire logic [kct_pkg::KEY_W-1:0]     entry_key,
  input  wire logic [kct_pkg::HANDLE_W-1:0]  entry_handle,
  output logic                               done,
  output logic      [kct_pkg::STATUS_W-1:0]  status,
  output logic      [kct_pkg::POS_W-1:0]     found_position,
  output logic      [kct_pkg::HANDLE_W-1:0]  handle_out,
  output logic      [kct_pkg::COUNT_W-1:0]   entry_count
);
  import kct_pkg::*;

  kct_ctl_t ctl;

  // Sequencer for the compare and execute steps.
  kct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // Table cells, compare and result logic.
  kct_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .command        (command),
    .entry_key      (entry_key),
    .entry_handle   (entry_handle),
    .status         (status),
    .found_position (found_position),
    .handle_out     (handle_out),
    .entry_count    (entry_count)
  );

endmodule

`default_nettype wire
